/* src/fastcgi_record_deframer_assert.svh */
// ----------------------------------------------------------------------------
// FastCGI record deframer assertion macros
// Concurrent check wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FASTCGI_RECORD_DEFRAMER_ASSERT_SVH
`define FASTCGI_RECORD_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcd assertion failed");

`endif

/* src/fcd_pkg.sv */
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types, protocol constants and helpers of the FastCGI deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcd_pkg;

  localparam logic [7:0] PROTO_VERSION      = 8'd1;
  localparam logic [7:0] MAX_REC_TYPE       = 8'd11;
  localparam logic [7:0] REC_STDOUT         = 8'd6;
  localparam logic [7:0] REC_STDERR         = 8'd7;
  localparam logic [7:0] REC_END_REQ        = 8'd3;
  localparam logic [7:0] PSTAT_COMPLETE     = 8'd0;
  localparam logic [7:0] PSTAT_CANT_MPX     = 8'd1;
  localparam logic [7:0] PSTAT_OVERLOADED   = 8'd2;
  localparam logic [7:0] PSTAT_UNKNOWN_ROLE = 8'd3;

  localparam logic [2:0] HDR_LAST_IDX  = 3'd7;
  localparam logic [2:0] HDR_VER_IDX   = 3'd0;
  localparam logic [2:0] HDR_TYPE_IDX  = 3'd1;
  localparam logic [2:0] HDR_CLEN_HI   = 3'd4;
  localparam logic [2:0] HDR_CLEN_LO   = 3'd5;
  localparam logic [2:0] HDR_PAD_IDX   = 3'd6;
  localparam logic [2:0] END_PSTAT_IDX = 3'd4;
  localparam logic [15:0] END_BODY_LEN = 16'd8;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_CONTENT = 3'd1,
    PH_ENDBODY = 3'd2,
    PH_PADDING = 3'd3,
    PH_DONE    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_STDOUT   = 2'd0,
    KIND_STDERR   = 2'd1,
    KIND_FINISHED = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_BAD_TYPE    = 3'd2,
    ST_BAD_RECORD  = 3'd3,
    ST_CANT_MPX    = 3'd4,
    ST_OVERLOADED  = 3'd5,
    ST_UNKNOWN_ROLE = 3'd6
  } status_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    status_e     code;
    logic [31:0] app;
  } result_t;

  // Map the end-request protocol status byte to a result status code.
  function automatic status_e map_pstat(input logic [7:0] ps);
    status_e code;
    case (ps)
      PSTAT_COMPLETE:     code = ST_OK;
      PSTAT_CANT_MPX:     code = ST_CANT_MPX;
      PSTAT_OVERLOADED:   code = ST_OVERLOADED;
      PSTAT_UNKNOWN_ROLE: code = ST_UNKNOWN_ROLE;
      default:            code = ST_BAD_RECORD;
    endcase
    return code;
  endfunction

endpackage

/* src/fcd_frame_fsm.sv */
// ----------------------------------------------------------------------------
// fcd_frame_fsm
// Record framing state and per-byte decision logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_frame_fsm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output fcd_pkg::result_t res_o
);
  import fcd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] clen_q, clen_d;
  logic [7:0]  pad_q, pad_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  pstat_q, pstat_d;
  status_e     esc_q, esc_d;

  logic        err;
  status_e     err_code;
  logic        fin;
  status_e     fin_code;
  logic        emit_data;
  kind_e       data_kind;
  logic        data_last;
  logic [15:0] clen_dec;
  logic [7:0]  pad_dec;

  // Next-state logic.
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    type_d   = type_q;
    clen_d   = clen_q;
    pad_d    = pad_q;
    acc_d    = acc_q;
    pstat_d  = pstat_q;
    esc_d    = esc_q;
    err      = 1'b0;
    err_code = ST_OK;
    fin      = 1'b0;
    fin_code = esc_q;
    emit_data = 1'b0;
    data_kind = KIND_STDOUT;
    data_last = 1'b0;
    clen_dec = clen_q - 16'd1;
    pad_dec  = (pad_q != 8'd0) ? (pad_q - 8'd1) : pad_q;

    case (phase_q)
      PH_HEADER: begin
        case (idx_q)
          HDR_VER_IDX: begin
            if (byte_i != PROTO_VERSION) begin
              err      = 1'b1;
              err_code = ST_BAD_VERSION;
            end
          end
          HDR_TYPE_IDX: begin
            if (byte_i > MAX_REC_TYPE) begin
              err      = 1'b1;
              err_code = ST_BAD_TYPE;
            end else begin
              type_d = byte_i;
            end
          end
          HDR_CLEN_HI: clen_d = {byte_i, 8'h00};
          HDR_CLEN_LO: clen_d = {clen_q[15:8], byte_i};
          HDR_PAD_IDX: pad_d  = byte_i;
          default: ;
        endcase
        if (!err) begin
          if (idx_q != HDR_LAST_IDX) begin
            idx_d = idx_q + 3'd1;
          end else begin
            idx_d = 3'd0;
            if (type_q == REC_END_REQ) begin
              if (clen_q != END_BODY_LEN) begin
                err      = 1'b1;
                err_code = ST_BAD_RECORD;
              end else begin
                acc_d   = 32'd0;
                phase_d = PH_ENDBODY;
              end
            end else if (clen_q != 16'd0) begin
              phase_d = PH_CONTENT;
            end else begin
              phase_d = (pad_q != 8'd0) ? PH_PADDING : PH_HEADER;
            end
          end
        end
      end
      PH_CONTENT: begin
        clen_d    = clen_dec;
        data_last = (clen_dec == 16'd0);
        if (data_last) begin
          idx_d   = 3'd0;
          phase_d = (pad_q != 8'd0) ? PH_PADDING : PH_HEADER;
        end
        if (type_q == REC_STDOUT) begin
          emit_data = 1'b1;
          data_kind = KIND_STDOUT;
        end else if (type_q == REC_STDERR) begin
          emit_data = 1'b1;
          data_kind = KIND_STDERR;
        end
      end
      PH_ENDBODY: begin
        if (idx_q < END_PSTAT_IDX) begin
          acc_d = {acc_q[23:0], byte_i};
        end else if (idx_q == END_PSTAT_IDX) begin
          pstat_d = byte_i;
        end
        if (idx_q != HDR_LAST_IDX) begin
          idx_d = idx_q + 3'd1;
        end else begin
          idx_d    = 3'd0;
          clen_d   = 16'd0;
          esc_d    = map_pstat(pstat_q);
          fin_code = esc_d;
          if (pad_q == 8'd0) begin
            fin     = 1'b1;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_PADDING;
          end
        end
      end
      PH_PADDING: begin
        pad_d = pad_dec;
        if (pad_dec == 8'd0) begin
          idx_d = 3'd0;
          if (type_q == REC_END_REQ) begin
            fin     = 1'b1;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_HEADER;
          end
        end
      end
      default: ;
    endcase

    if (err) begin
      phase_d = PH_ERROR;
    end
  end

  // Result of the current byte.
  always_comb begin
    res_o = '0;
    if (err) begin
      res_o.valid = 1'b1;
      res_o.kind  = KIND_ERROR;
      res_o.code  = err_code;
    end else if (fin) begin
      res_o.valid = 1'b1;
      res_o.kind  = KIND_FINISHED;
      res_o.code  = fin_code;
      res_o.app   = acc_q;
    end else if (emit_data) begin
      res_o.valid = 1'b1;
      res_o.kind  = data_kind;
      res_o.data  = byte_i;
      res_o.last  = data_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      idx_q   <= 3'd0;
      type_q  <= 8'd0;
      clen_q  <= 16'd0;
      pad_q   <= 8'd0;
      acc_q   <= 32'd0;
      pstat_q <= 8'd0;
      esc_q   <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      type_q  <= type_d;
      clen_q  <= clen_d;
      pad_q   <= pad_d;
      acc_q   <= acc_d;
      pstat_q <= pstat_d;
      esc_q   <= esc_d;
    end
  end

endmodule

/* src/fcd_out_reg.sv */
// ----------------------------------------------------------------------------
// fcd_out_reg
// Result register with valid/ready handshake toward the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  fcd_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             free_o,
  output fcd_pkg::result_t res_o
);
  import fcd_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // Register may take a new result when empty or when being drained now.
  assign free_o  = !valid_q || ready_i;
  assign valid_d = (load_i && res_i.valid) ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      data_q <= res_i;
    end
  end

  always_comb begin
    res_o       = data_q;
    res_o.valid = valid_q;
  end

endmodule

/* src/fastcgi_record_deframer.sv */
// ----------------------------------------------------------------------------
// fastcgi_record_deframer
// Byte-stream FastCGI record deframer with tagged content and finish report.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one raw byte per transaction
//   from the application server. Output channel (out_valid_o/out_ready_i)
//   carries zero or one result per input byte: a stdout or stderr content
//   byte, a request-finished report with the application exit status and a
//   status code, or a framing error.
//   A result appears on the output in the cycle after its byte is taken.
//   Throughput: one byte per cycle; every decision is a single pass of logic
//   from the framing state and the incoming byte into the result register.
//   A stalled receiver holds the result register; the input keeps taking
//   bytes while the held result is being drained in the same cycle, and
//   stops only while the result register is full and not read.
//   Reset puts the framer at the start of a record header with all counters
//   cleared and empties the result register. Framing errors and completion
//   are sticky: later bytes are swallowed without results until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fastcgi_record_deframer_assert.svh"

module fastcgi_record_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_of_record_o,
  output logic [2:0]  status_code_o,
  output logic [31:0] app_exit_status_o
);
  import fcd_pkg::*;

  logic    step;
  logic    out_free;
  result_t fsm_res;
  result_t out_res;

  // Take a byte whenever the result register can absorb what it produces.
  assign in_ready_o = out_free;
  assign step       = in_valid_i && out_free;

  // Framing state and per-byte decisions.
  fcd_frame_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (stream_byte_i),
    .res_o  (fsm_res)
  );

  // Hold the result until the receiver takes the transaction.
  fcd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (fsm_res),
    .ready_i (out_ready_i),
    .free_o  (out_free),
    .res_o   (out_res)
  );

  assign out_valid_o       = out_res.valid;
  assign out_kind_o        = out_res.kind;
  assign out_byte_o        = out_res.data;
  assign last_of_record_o  = out_res.last;
  assign status_code_o     = out_res.code;
  assign app_exit_status_o = out_res.app;

  // Content bytes carry no status and no exit code.
  `FCD_ASSERT_NOW(a_data_clean,
    out_valid_o && (out_kind_o == KIND_STDOUT || out_kind_o == KIND_STDERR),
    status_code_o == ST_OK && app_exit_status_o == 32'd0)

  // End-of-record flag only marks content bytes.
  `FCD_ASSERT_NOW(a_last_on_data, out_valid_o && last_of_record_o,
    out_kind_o == KIND_STDOUT || out_kind_o == KIND_STDERR)

  // A delivered framing error is the final result until reset.
  `FCD_ASSERT_NEXT(a_error_sticky,
    out_valid_o && out_ready_i && out_kind_o == KIND_ERROR, !out_valid_o)

  // A delivered finish report is the final result until reset.
  `FCD_ASSERT_NEXT(a_finish_sticky,
    out_valid_o && out_ready_i && out_kind_o == KIND_FINISHED, !out_valid_o)

endmodule

/* tb/fastcgi_record_deframer_tb.sv */
// ----------------------------------------------------------------------------
// fastcgi_record_deframer_tb
// Self-checking bench for the FastCGI record deframer: sends byte streams of
// well-formed records with random content, closes each run with one request
// end, framing fault or noise, and checks every result against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fastcgi_record_deframer_tb;
  import fcd_pkg::*;

  // Run length and watchdog.
  localparam int unsigned RANDOM_BYTES = 1850;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTS   = 40;

  // Ways a run can close. Errors and completion are sticky, and reset is
  // applied once, so every run ends in exactly one of these.
  typedef enum int {
    END_COMPLETE,
    END_CANT_MPX,
    END_OVERLOADED,
    END_UNKNOWN_ROLE,
    END_ODD_PSTAT,
    END_BAD_VERSION,
    END_BAD_TYPE,
    END_BAD_LENGTH,
    END_NOISE
  } ending_e;

  // One result as the block should present it.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    status_e     code;
    logic [31:0] app;
  } deframed_t;

  // Stimulus side: every input holds a known value from time zero.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  stream_byte_i = 8'h00;
  logic        out_ready_i   = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_byte_o;
  logic        last_of_record_o;
  logic [2:0]  status_code_o;
  logic [31:0] app_exit_status_o;

  // Long stretch with no idling on either side while set.
  bit          steady_flow   = 1'b0;
  int unsigned bytes_sent    = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;

  // Results predicted for accepted bytes and not yet seen on the output.
  deframed_t   pending_results[$];

  // Predictor copy of the framing state, at its reset values.
  phase_e      fr_phase    = PH_HEADER;
  logic [2:0]  hdr_idx     = 3'd0;
  logic [7:0]  rec_type    = 8'h00;
  logic [15:0] content_cnt = 16'h0000;
  logic [7:0]  pad_cnt     = 8'h00;
  logic [31:0] exit_acc    = 32'h0;
  logic [7:0]  pstat_byte  = 8'h00;
  status_e     finish_code = ST_OK;

  fastcgi_record_deframer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .stream_byte_i     (stream_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_kind_o        (out_kind_o),
    .out_byte_o        (out_byte_o),
    .last_of_record_o  (last_of_record_o),
    .status_code_o     (status_code_o),
    .app_exit_status_o (app_exit_status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Enter the sticky error phase and build the error report.
  function automatic deframed_t framing_fault(input status_e code);
    deframed_t r;
    fr_phase = PH_ERROR;
    r = '{kind: KIND_ERROR, data: 8'h00, last: 1'b0, code: code, app: 32'h0};
    return r;
  endfunction

  // Enter the done phase and build the finished report.
  function automatic deframed_t request_finished();
    deframed_t r;
    fr_phase = PH_DONE;
    r = '{kind: KIND_FINISHED, data: 8'h00, last: 1'b0, code: finish_code,
          app: exit_acc};
    return r;
  endfunction

  // Content is used up: skip padding if there is any, else expect a header.
  function automatic void leave_content();
    hdr_idx  = 3'd0;
    fr_phase = (pad_cnt != 8'h00) ? PH_PADDING : PH_HEADER;
  endfunction

  // Advance the framing state by one byte; return 1 when a result follows.
  function automatic bit deframe_byte(input logic [7:0] b, output deframed_t r);
    logic at_end;
    r = '0;
    case (fr_phase)
      PH_HEADER: begin
        case (hdr_idx)
          HDR_VER_IDX: begin
            if (b != PROTO_VERSION) begin
              r = framing_fault(ST_BAD_VERSION);
              return 1'b1;
            end
          end
          HDR_TYPE_IDX: begin
            if (b > MAX_REC_TYPE) begin
              r = framing_fault(ST_BAD_TYPE);
              return 1'b1;
            end
            rec_type = b;
          end
          HDR_CLEN_HI: content_cnt = {b, 8'h00};
          HDR_CLEN_LO: content_cnt = content_cnt | {8'h00, b};
          HDR_PAD_IDX: pad_cnt = b;
          default: ;
        endcase
        if (hdr_idx != HDR_LAST_IDX) begin
          hdr_idx = hdr_idx + 3'd1;
          return 1'b0;
        end
        hdr_idx = 3'd0;
        if (rec_type == REC_END_REQ) begin
          // An end-request body has a fixed size; anything else is fatal.
          if (content_cnt != END_BODY_LEN) begin
            r = framing_fault(ST_BAD_RECORD);
            return 1'b1;
          end
          exit_acc = 32'h0;
          fr_phase = PH_ENDBODY;
        end else if (content_cnt != 16'h0000) begin
          fr_phase = PH_CONTENT;
        end else begin
          leave_content();
        end
        return 1'b0;
      end

      PH_CONTENT: begin
        content_cnt = content_cnt - 16'd1;
        at_end      = (content_cnt == 16'h0000);
        if (at_end) leave_content();
        if (rec_type == REC_STDOUT) begin
          r = '{kind: KIND_STDOUT, data: b, last: at_end, code: ST_OK, app: 32'h0};
          return 1'b1;
        end
        if (rec_type == REC_STDERR) begin
          r = '{kind: KIND_STDERR, data: b, last: at_end, code: ST_OK, app: 32'h0};
          return 1'b1;
        end
        return 1'b0;
      end

      PH_ENDBODY: begin
        // Status arrives most significant byte first, then the protocol status.
        if (hdr_idx < END_PSTAT_IDX) exit_acc = {exit_acc[23:0], b};
        else if (hdr_idx == END_PSTAT_IDX) pstat_byte = b;
        if (hdr_idx != HDR_LAST_IDX) begin
          hdr_idx = hdr_idx + 3'd1;
          return 1'b0;
        end
        hdr_idx     = 3'd0;
        content_cnt = 16'h0000;
        case (pstat_byte)
          PSTAT_COMPLETE:     finish_code = ST_OK;
          PSTAT_CANT_MPX:     finish_code = ST_CANT_MPX;
          PSTAT_OVERLOADED:   finish_code = ST_OVERLOADED;
          PSTAT_UNKNOWN_ROLE: finish_code = ST_UNKNOWN_ROLE;
          default:            finish_code = ST_BAD_RECORD;
        endcase
        if (pad_cnt == 8'h00) begin
          r = request_finished();
          return 1'b1;
        end
        fr_phase = PH_PADDING;
        return 1'b0;
      end

      PH_PADDING: begin
        if (pad_cnt != 8'h00) pad_cnt = pad_cnt - 8'd1;
        if (pad_cnt == 8'h00) begin
          hdr_idx = 3'd0;
          // Padding of an end request closes the request.
          if (rec_type == REC_END_REQ) begin
            r = request_finished();
            return 1'b1;
          end
          fr_phase = PH_HEADER;
        end
        return 1'b0;
      end

      // Done and error swallow every byte.
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < MAX_PRINTS) begin
      $display("MISMATCH at cycle %0d: %s got 0x%0h, want 0x%0h",
               cycle_cnt, what, got, want);
    end
    mismatch_cnt++;
  endtask

  // Check the output transaction first: it belongs to bytes taken earlier.
  // Then predict for the input transaction of this edge. One process does
  // both, so the order within the time step is fixed.
  always @(posedge clk_i) begin
    deframed_t want;
    deframed_t res;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, kind", out_kind_o, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_kind_o !== want.kind)
            report_mismatch("out_kind", out_kind_o, want.kind);
          if (out_byte_o !== want.data)
            report_mismatch("out_byte", out_byte_o, want.data);
          if (last_of_record_o !== want.last)
            report_mismatch("last_of_record", last_of_record_o, want.last);
          if (status_code_o !== want.code)
            report_mismatch("status_code", status_code_o, want.code);
          if (app_exit_status_o !== want.app)
            report_mismatch("app_exit_status", app_exit_status_o, want.app);
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (deframe_byte(stream_byte_i, res)) pending_results.push_back(res);
      end
    end
  end

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("fastcgi_record_deframer_tb NOT OK");
      $finish;
    end
  end

  // Receiver: stall about a third of the cycles unless the flow is steady.
  always @(negedge clk_i) begin
    out_ready_i <= steady_flow ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Send one byte as one transaction: idle at random, then hold valid and
  // the byte until the block takes them.
  task automatic send_byte(input logic [7:0] b);
    if (!steady_flow && $urandom_range(99) < 33) begin
      repeat ($urandom_range(1, 2)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Send an 8-byte header; request id and reserved byte are random.
  task automatic send_header(input logic [7:0] ver, input logic [7:0] rtype,
                             input logic [15:0] clen, input logic [7:0] plen);
    send_byte(ver);
    send_byte(rtype);
    send_byte(8'($urandom_range(255)));
    send_byte(8'($urandom_range(255)));
    send_byte(clen[15:8]);
    send_byte(clen[7:0]);
    send_byte(plen);
    send_byte(8'($urandom_range(255)));
  endtask

  // Send a well-formed record with random content and padding bytes.
  task automatic send_record(input logic [7:0] rtype, input int unsigned clen,
                             input int unsigned plen);
    send_header(PROTO_VERSION, rtype, 16'(clen), 8'(plen));
    repeat (clen) send_byte(8'($urandom_range(255)));
    repeat (plen) send_byte(8'($urandom_range(255)));
  endtask

  // Short records: one stdout byte, an empty stderr record that goes
  // straight to padding, and discarded content of the highest legal type.
  task automatic test_directed_records();
    send_record(REC_STDOUT, 1, 0);
    send_record(REC_STDERR, 0, 1);
    send_record(MAX_REC_TYPE, 1, 0);
  endtask

  // Well-formed records of every legal type except end request. Mostly
  // stdout and stderr with short content; now and then a long record or
  // the longest padding. Hold a steady stretch in the middle.
  task automatic test_random_records();
    logic [7:0]  rtype;
    int unsigned clen;
    int unsigned plen;
    int unsigned pick;
    while (bytes_sent < RANDOM_BYTES) begin
      steady_flow = (bytes_sent >= 700 && bytes_sent < 1100);
      pick = $urandom_range(9);
      if (pick < 4) rtype = REC_STDOUT;
      else if (pick < 7) rtype = REC_STDERR;
      else begin
        rtype = 8'($urandom_range(MAX_REC_TYPE));
        if (rtype == REC_END_REQ) rtype = REC_STDOUT;
      end
      pick = $urandom_range(19);
      if (pick == 0) clen = 0;
      else if (pick == 19 && bytes_sent + 1000 < RANDOM_BYTES)
        clen = $urandom_range(200, 700);
      else clen = $urandom_range(1, 24);
      plen = ($urandom_range(24) == 0) ? 255 : $urandom_range(7);
      send_record(rtype, clen, plen);
    end
    steady_flow = 1'b0;
  endtask

  // Close the request in one of the ways picked at random: a finished
  // report with each protocol status, one of the framing faults, or raw noise.
  task automatic test_request_end();
    ending_e     how;
    logic [7:0]  pstat;
    logic [7:0]  plen;
    logic [31:0] app;
    bit          finishes;
    how      = ending_e'($urandom_range(END_NOISE));
    finishes = 1'b1;
    pstat    = PSTAT_COMPLETE;
    plen     = 8'($urandom_range(7));
    case (how)
      END_COMPLETE:     plen  = 8'h00;
      END_CANT_MPX:     pstat = PSTAT_CANT_MPX;
      END_OVERLOADED:   pstat = PSTAT_OVERLOADED;
      END_UNKNOWN_ROLE: pstat = PSTAT_UNKNOWN_ROLE;
      END_ODD_PSTAT:    pstat = 8'($urandom_range(4, 255));
      END_BAD_VERSION: begin
        finishes = 1'b0;
        send_header($urandom_range(1) ? 8'h00 : 8'($urandom_range(2, 255)),
                    REC_STDOUT, 16'd4, 8'h00);
      end
      END_BAD_TYPE: begin
        finishes = 1'b0;
        send_header(PROTO_VERSION, 8'($urandom_range(12, 255)), 16'd4, 8'h00);
      end
      END_BAD_LENGTH: begin
        finishes = 1'b0;
        case ($urandom_range(3))
          0:       send_header(PROTO_VERSION, REC_END_REQ, 16'd0, plen);
          1:       send_header(PROTO_VERSION, REC_END_REQ, 16'd7, plen);
          2:       send_header(PROTO_VERSION, REC_END_REQ, 16'd9, plen);
          default: send_header(PROTO_VERSION, REC_END_REQ, 16'hFFFF, plen);
        endcase
      end
      default: begin
        // Raw noise; the predictor follows whatever it happens to frame.
        finishes = 1'b0;
        repeat (16) send_byte(8'($urandom_range(255)));
      end
    endcase
    if (finishes) begin
      app = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
      send_header(PROTO_VERSION, REC_END_REQ, END_BODY_LEN, plen);
      send_byte(app[31:24]);
      send_byte(app[23:16]);
      send_byte(app[15:8]);
      send_byte(app[7:0]);
      send_byte(pstat);
      repeat (3) send_byte(8'($urandom_range(255)));
      repeat (plen) send_byte(8'($urandom_range(255)));
    end
  endtask

  // After completion or a fault every byte must be swallowed; a legal
  // stdout header in the tail would otherwise produce output.
  task automatic test_sticky_tail();
    send_record(REC_STDOUT, 2, 0);
    repeat (6) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_records();
    test_random_records();
    test_request_end();
    test_sticky_tail();

    // Drop valid, drain every pending result, then watch a few more cycles
    // for stray output.
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    steady_flow = 1'b1;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("fastcgi_record_deframer_tb OK");
    end else begin
      $display("fastcgi_record_deframer_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/fcd_pkg.sv
src/fcd_frame_fsm.sv
src/fcd_out_reg.sv
src/fastcgi_record_deframer.sv
tb/fastcgi_record_deframer_tb.sv
